// ===== src/rfd_pkg.sv =====
// Shared constants and types of the pulse frame decoder.
package rfd_pkg;

  // Ring geometry
  localparam int RING_DEPTH = 50;
  localparam int PTR_W      = $clog2(RING_DEPTH);
  localparam int IVL_W      = 16;

  // Code geometry: one sync read plus four reads per bit
  localparam int CODE_BITS  = 12;
  localparam int WALK_READS = 1 + 4 * CODE_BITS;
  localparam int IDX_W      = $clog2(WALK_READS);

  // Groups that must each hold a set bit
  localparam logic [CODE_BITS-1:0] GROUP_A = 12'b111110000000;
  localparam logic [CODE_BITS-1:0] GROUP_B = 12'b000001111100;
  localparam logic [CODE_BITS-1:0] GROUP_C = 12'b000000000011;

  // Configuration registers
  localparam int UNIT_W = 12;
  localparam int TOL_W  = 11;
  localparam int GAP_W  = 15;
  localparam int CFG_W  = 15;
  localparam int CIDX_W = 2;

  localparam logic [CIDX_W-1:0] CFG_UNIT = 2'd0;
  localparam logic [CIDX_W-1:0] CFG_TOL  = 2'd1;
  localparam logic [CIDX_W-1:0] CFG_GAP  = 2'd2;

  localparam logic [UNIT_W-1:0] UNIT_RST = 12'd300;
  localparam logic [TOL_W-1:0]  TOL_RST  = 11'd75;
  localparam logic [GAP_W-1:0]  GAP_RST  = 15'd5000;

  // Result status codes
  localparam logic [1:0] ST_NO_SYNC = 2'd0;
  localparam logic [1:0] ST_BAD     = 2'd1;
  localparam logic [1:0] ST_OK      = 2'd2;

  typedef struct packed {
    logic [UNIT_W-1:0] unit;
    logic [TOL_W-1:0]  tol;
    logic [GAP_W-1:0]  gap;
  } cfg_t;

  // One write and one read access to the interval ring
  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [IVL_W-1:0] wdata;
    logic             re;
    logic [PTR_W-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic [1:0]           status;
    logic [CODE_BITS-1:0] code;
    logic [IVL_W-1:0]     sync_width;
    logic                 groups_ok;
  } result_t;

endpackage

// ===== src/rfd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rfd_ram #(
  parameter  int WIDTH = 16,
  parameter  int DEPTH = 50,
  localparam int AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/rfd_ring.sv =====
// Interval ring: RAM plus per-entry valid bits so unwritten entries read as zero.
module rfd_ring (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  rfd_pkg::ring_req_t       req_i,
  output logic [rfd_pkg::IVL_W-1:0] rdata_o
);

  logic [rfd_pkg::RING_DEPTH-1:0] vld_q, vld_d;
  logic                           rvld_q;
  logic [rfd_pkg::IVL_W-1:0]      ram_rdata;

  rfd_ram #(
    .WIDTH(rfd_pkg::IVL_W),
    .DEPTH(rfd_pkg::RING_DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (req_i.we),
    .waddr_i(req_i.waddr),
    .wdata_i(req_i.wdata),
    .re_i   (req_i.re),
    .raddr_i(req_i.raddr),
    .rdata_o(ram_rdata)
  );

  // Mark written entries
  always_comb begin
    vld_d = vld_q;
    if (req_i.we) begin
      vld_d[req_i.waddr] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      if (req_i.re) begin
        rvld_q <= vld_q[req_i.raddr];
      end
    end
  end

  // Entries never written read as zero
  assign rdata_o = rvld_q ? ram_rdata : '0;

endmodule

// ===== src/rfd_ctrl.sv =====
// Frame sequencer: stores intervals, walks the ring back on a gap, builds the result.
module rfd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rfd_pkg::cfg_t             cfg_i,
  input  logic                      in_valid_i,
  output logic                      in_ready_o,
  input  logic [rfd_pkg::IVL_W-1:0] interval_i,
  output rfd_pkg::ring_req_t        ring_req_o,
  input  logic [rfd_pkg::IVL_W-1:0] ring_rdata_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output rfd_pkg::result_t          res_o
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_WALK   = 2'd1;
  localparam logic [1:0] S_RESULT = 2'd2;

  localparam logic [rfd_pkg::IDX_W-1:0] IDX_LAST = rfd_pkg::IDX_W'(rfd_pkg::WALK_READS - 1);
  localparam logic [rfd_pkg::PTR_W-1:0] PTR_LAST = rfd_pkg::PTR_W'(rfd_pkg::RING_DEPTH - 1);

  localparam int BW = 19;

  function automatic logic [rfd_pkg::PTR_W-1:0] ptr_inc(input logic [rfd_pkg::PTR_W-1:0] p);
    ptr_inc = (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [rfd_pkg::PTR_W-1:0] ptr_dec(input logic [rfd_pkg::PTR_W-1:0] p);
    ptr_dec = (p == '0) ? PTR_LAST : p - 1'b1;
  endfunction

  logic [1:0]                     state_q, state_d;
  logic [rfd_pkg::PTR_W-1:0]      ptr_q, ptr_d;
  logic [rfd_pkg::PTR_W-1:0]      rd_ptr_q, rd_ptr_d;
  logic [rfd_pkg::IDX_W-1:0]      iss_idx_q, iss_idx_d;
  logic                           iss_done_q, iss_done_d;
  logic                           dat_vld_q, dat_vld_d;
  logic [rfd_pkg::IDX_W-1:0]      dat_idx_q, dat_idx_d;
  logic [rfd_pkg::PTR_W-1:0]      dat_addr_q, dat_addr_d;
  logic [rfd_pkg::IVL_W-1:0]      sync_q, sync_d;
  logic [rfd_pkg::CODE_BITS-1:0]  code_q, code_d;
  logic                           p2s_q, p2s_d, p2l_q, p2l_d, p1l_q, p1l_d;
  rfd_pkg::result_t               res_q, res_d;

  logic                           accept, is_gap, issue, finish;
  logic [1:0]                     fin_status;
  logic [rfd_pkg::CODE_BITS-1:0]  fin_code, code_nx;
  logic                           grp_good;
  logic signed [BW-1:0]           lo1, hi1, lo3, hi3, xs;
  logic                           is_short, is_long;

  // Short and long windows, signed so a low bound may fall below zero
  always_comb begin
    lo1 = $signed({{(BW-rfd_pkg::UNIT_W){1'b0}}, cfg_i.unit})
        - $signed({{(BW-rfd_pkg::TOL_W){1'b0}}, cfg_i.tol});
    hi1 = $signed({{(BW-rfd_pkg::UNIT_W){1'b0}}, cfg_i.unit})
        + $signed({{(BW-rfd_pkg::TOL_W){1'b0}}, cfg_i.tol});
    lo3 = lo1 + (lo1 <<< 1);
    hi3 = hi1 + (hi1 <<< 1);
    xs  = $signed({{(BW-rfd_pkg::IVL_W){1'b0}}, ring_rdata_i});
    is_short = (xs >= lo1) && (xs <= hi1);
    is_long  = (xs >= lo3) && (xs <= hi3);
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign accept      = in_valid_i && in_ready_o;
  assign is_gap      = (interval_i > {1'b0, cfg_i.gap});
  assign res_valid_o = (state_q == S_RESULT);
  assign res_o       = res_q;

  // Evaluate the entry that arrived from the ring
  always_comb begin
    finish     = 1'b0;
    fin_status = rfd_pkg::ST_BAD;
    fin_code   = '0;
    sync_d     = sync_q;
    code_d     = code_q;
    p2s_d      = p2s_q;
    p2l_d      = p2l_q;
    p1l_d      = p1l_q;
    grp_good   = is_short && p1l_q && (p2s_q || p2l_q);
    code_nx    = {p2s_q, code_q[rfd_pkg::CODE_BITS-1:1]};
    if (accept) begin
      code_d = '0;
    end
    if (dat_vld_q) begin
      if (dat_idx_q == '0) begin
        if (!is_short) begin
          finish     = 1'b1;
          fin_status = rfd_pkg::ST_NO_SYNC;
        end else begin
          sync_d = ring_rdata_i;
        end
      end else begin
        case (dat_idx_q[1:0])
          2'd2: begin
            p2s_d = is_short;
            p2l_d = is_long;
          end
          2'd3: begin
            p1l_d = is_long;
          end
          2'd0: begin
            if (!grp_good) begin
              finish = 1'b1;
            end else begin
              code_d = code_nx;
              if (dat_idx_q == IDX_LAST) begin
                finish     = 1'b1;
                fin_code   = code_nx;
                fin_status = (code_nx != '0) ? rfd_pkg::ST_OK : rfd_pkg::ST_BAD;
              end
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Sequence the walk and the ring accesses
  always_comb begin
    state_d    = state_q;
    ptr_d      = ptr_q;
    rd_ptr_d   = rd_ptr_q;
    iss_idx_d  = iss_idx_q;
    iss_done_d = iss_done_q;
    res_d      = res_q;
    issue      = (state_q == S_WALK) && !iss_done_q && !finish;
    ring_req_o = '0;
    if (issue) begin
      ring_req_o.re    = 1'b1;
      ring_req_o.raddr = rd_ptr_q;
      rd_ptr_d         = ptr_dec(rd_ptr_q);
      iss_idx_d        = iss_idx_q + 1'b1;
      iss_done_d       = (iss_idx_q == IDX_LAST);
    end
    dat_vld_d  = issue;
    dat_idx_d  = iss_idx_q;
    dat_addr_d = rd_ptr_q;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (is_gap) begin
            rd_ptr_d   = ptr_dec(ptr_q);
            iss_idx_d  = '0;
            iss_done_d = 1'b0;
            state_d    = S_WALK;
          end else begin
            ring_req_o.we    = 1'b1;
            ring_req_o.waddr = ptr_q;
            ring_req_o.wdata = interval_i;
            ptr_d            = ptr_inc(ptr_q);
          end
        end
      end
      S_WALK: begin
        if (finish) begin
          ring_req_o.we    = 1'b1;
          ring_req_o.waddr = dat_addr_q;
          ring_req_o.wdata = '0;
          ptr_d            = ptr_inc(dat_addr_q);
          res_d.status     = fin_status;
          res_d.code       = fin_code;
          res_d.sync_width = (fin_status == rfd_pkg::ST_OK) ? sync_q : '0;
          res_d.groups_ok  = ((fin_code & rfd_pkg::GROUP_A) != '0)
                          && ((fin_code & rfd_pkg::GROUP_B) != '0)
                          && ((fin_code & rfd_pkg::GROUP_C) != '0);
          state_d          = S_RESULT;
        end
      end
      S_RESULT: begin
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      ptr_q      <= '0;
      iss_done_q <= 1'b1;
      dat_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      ptr_q      <= ptr_d;
      iss_done_q <= iss_done_d;
      dat_vld_q  <= dat_vld_d;
    end
  end

  // Walk payload
  always_ff @(posedge clk_i) begin
    rd_ptr_q   <= rd_ptr_d;
    iss_idx_q  <= iss_idx_d;
    dat_idx_q  <= dat_idx_d;
    dat_addr_q <= dat_addr_d;
    sync_q     <= sync_d;
    code_q     <= code_d;
    p2s_q      <= p2s_d;
    p2l_q      <= p2l_d;
    p1l_q      <= p1l_d;
    res_q      <= res_d;
  end

endmodule

// ===== src/rf_remote_pulse_frame_decoder.sv =====
// Top level of the remote-control pulse frame decoder: config, ring, sequencer, output register.
//
// Each transaction on the input stream carries one edge-to-edge interval. An interval at or
// below the gap threshold is stored in a 50-entry ring memory and gives no result. A longer
// interval ends a frame: the sequencer reads the ring backwards through its single read
// port, one entry per cycle (the sync pulse, then four entries per bit for twelve bits), and
// stops early when the sync pulse or a bit group is rejected. Every gap yields exactly one
// result transaction; while it waits in the output register the next interval is already
// accepted. The ring reads as zero after reset without any clearing pass. Configuration
// writes take effect at once and are meant to be issued while the block is idle.
module rf_remote_pulse_frame_decoder (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // Configuration write port
  input  logic                        cfg_we_i,
  input  logic [rfd_pkg::CIDX_W-1:0]  cfg_idx_i,
  input  logic [rfd_pkg::CFG_W-1:0]   cfg_data_i,
  // Interval stream
  input  logic                        s_axis_tvalid,
  output logic                        s_axis_tready,
  input  logic [15:0]                 s_axis_tdata,  // [15:0] interval_us
  // Result stream
  output logic                        m_axis_tvalid,
  input  logic                        m_axis_tready,
  output logic [31:0]                 m_axis_tdata   // [1:0] status, [13:2] code,
                                                     // [29:14] sync_width_us, [30] groups_ok
);

  rfd_pkg::cfg_t                 cfg_q;
  rfd_pkg::ring_req_t            ring_req;
  logic [rfd_pkg::IVL_W-1:0]     ring_rdata;
  logic                          res_valid, res_ready;
  rfd_pkg::result_t              res;
  logic                          out_vld_q;
  rfd_pkg::result_t              out_q;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.unit <= rfd_pkg::UNIT_RST;
      cfg_q.tol  <= rfd_pkg::TOL_RST;
      cfg_q.gap  <= rfd_pkg::GAP_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rfd_pkg::CFG_UNIT: cfg_q.unit <= cfg_data_i[rfd_pkg::UNIT_W-1:0];
        rfd_pkg::CFG_TOL:  cfg_q.tol  <= cfg_data_i[rfd_pkg::TOL_W-1:0];
        rfd_pkg::CFG_GAP:  cfg_q.gap  <= cfg_data_i[rfd_pkg::GAP_W-1:0];
        default: begin
        end
      endcase
    end
  end

  rfd_ring u_ring (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (ring_req),
    .rdata_o(ring_rdata)
  );

  rfd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .interval_i  (s_axis_tdata),
    .ring_req_o  (ring_req),
    .ring_rdata_i(ring_rdata),
    .res_valid_o (res_valid),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  // Output register: load when empty or being drained
  assign res_ready = !out_vld_q || m_axis_tready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      out_q <= res;
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = {1'b0, out_q.groups_ok, out_q.sync_width, out_q.code, out_q.status};

endmodule

// ===== src/rfd_checker.sv =====
// Port-level checks of the pulse frame decoder, bound to the top level.
module rfd_checker (
  input logic                       clk_i,
  input logic                       rst_ni,
  input logic                       m_axis_tvalid,
  input logic                       m_axis_tready,
  input logic [31:0]                m_axis_tdata
);

  // Hold a stalled result transaction unchanged
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // Status takes only its defined codes
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[1:0] != rfd_pkg::ST_BAD + rfd_pkg::ST_OK)
    else $error("undefined status code");

  // A failed frame carries no code, sync width or group flag
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] != rfd_pkg::ST_OK |-> m_axis_tdata[30:2] == '0)
    else $error("failed frame carries payload");

  // A decoded frame always has a nonzero code
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1:0] == rfd_pkg::ST_OK |-> m_axis_tdata[13:2] != '0)
    else $error("decoded frame with zero code");

  // Spare output bit stays clear
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !m_axis_tdata[31])
    else $error("padding bit set");

endmodule

bind rf_remote_pulse_frame_decoder rfd_checker u_rfd_checker (.*);

// ===== tb/rf_pulse_frame_checker.sv =====
`timescale 1ns / 100ps
// Checker for the pulse frame decoder: tracks the interval ring, predicts frame results, compares.
module rf_pulse_frame_checker (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cfg_we_i,
  input  logic [rfd_pkg::CIDX_W-1:0] cfg_idx_i,
  input  logic [rfd_pkg::CFG_W-1:0]  cfg_data_i,
  input  logic                       s_axis_tvalid,
  input  logic                       s_axis_tready,
  input  logic [15:0]                s_axis_tdata,   // [15:0] interval_us
  input  logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  input  logic [31:0]                m_axis_tdata,   // [1:0] status, [13:2] code,
                                                     // [29:14] sync_width_us, [30] groups_ok
  output int                         mismatches_o,
  output int                         frames_pending_o
);

  logic [rfd_pkg::IVL_W-1:0]  ring_copy [rfd_pkg::RING_DEPTH];
  int unsigned                ring_ptr;
  logic [rfd_pkg::UNIT_W-1:0] unit_us;
  logic [rfd_pkg::TOL_W-1:0]  tol_us;
  logic [rfd_pkg::GAP_W-1:0]  gap_us;
  rfd_pkg::result_t           frames_due [$];
  int                         mismatches;

  // Short pulse for units 1, long pulse for units 3; bounds are signed
  function automatic bit fits_pulse(input logic [rfd_pkg::IVL_W-1:0] width, input int units);
    int w, lo, hi;
    w  = int'(width);
    lo = units * (int'(unit_us) - int'(tol_us));
    hi = units * (int'(unit_us) + int'(tol_us));
    return (w >= lo) && (w <= hi);
  endfunction

  function automatic void store_interval(input logic [rfd_pkg::IVL_W-1:0] width);
    ring_copy[ring_ptr] = width;
    ring_ptr = (ring_ptr + 1 >= rfd_pkg::RING_DEPTH) ? 0 : ring_ptr + 1;
  endfunction

  function automatic logic [rfd_pkg::IVL_W-1:0] pop_interval();
    ring_ptr = (ring_ptr != 0) ? ring_ptr - 1 : rfd_pkg::RING_DEPTH - 1;
    return ring_copy[ring_ptr];
  endfunction

  // Fold one interval into the ring copy; a frame gap queues the result it produces
  function automatic void take_interval(input logic [rfd_pkg::IVL_W-1:0] width);
    rfd_pkg::result_t              res;
    logic [rfd_pkg::IVL_W-1:0]     sync, p0, p1, p2;
    logic [rfd_pkg::CODE_BITS-1:0] code;
    res  = '0;
    code = '0;
    if (width <= gap_us) begin
      store_interval(width);
      return;
    end
    sync = pop_interval();
    if (!fits_pulse(sync, 1)) begin
      store_interval('0);
      res.status = rfd_pkg::ST_NO_SYNC;
      frames_due.push_back(res);
      return;
    end
    // Walk back group by group, newest group first; the earliest bit ends in the MSB
    for (int b = 0; b < rfd_pkg::CODE_BITS; b++) begin
      void'(pop_interval());
      p2    = pop_interval();
      p1    = pop_interval();
      p0    = pop_interval();
      code  = code >> 1;
      if (!(fits_pulse(p0, 1) && fits_pulse(p1, 3))) begin
        code = '0;
        break;
      end
      if (fits_pulse(p2, 1)) begin
        code[rfd_pkg::CODE_BITS-1] = 1'b1;
      end else if (!fits_pulse(p2, 3)) begin
        code = '0;
        break;
      end
    end
    store_interval('0);
    res.code       = code;
    res.status     = (code != '0) ? rfd_pkg::ST_OK : rfd_pkg::ST_BAD;
    res.sync_width = (code != '0) ? sync : '0;
    res.groups_ok  = |(code & rfd_pkg::GROUP_A) && |(code & rfd_pkg::GROUP_B)
                  && |(code & rfd_pkg::GROUP_C);
    frames_due.push_back(res);
  endfunction

  // Compare results, track settings, predict from accepted intervals
  always @(posedge clk_i or negedge rst_ni) begin
    rfd_pkg::result_t want;
    if (!rst_ni) begin
      for (int i = 0; i < rfd_pkg::RING_DEPTH; i++) ring_copy[i] = '0;
      ring_ptr   = 0;
      unit_us    = rfd_pkg::UNIT_RST;
      tol_us     = rfd_pkg::TOL_RST;
      gap_us     = rfd_pkg::GAP_RST;
      mismatches = 0;
      frames_due.delete();
      mismatches_o     <= 0;
      frames_pending_o <= 0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (frames_due.size() == 0) begin
          $error("result transaction with no frame gap pending: tdata %h", m_axis_tdata);
          mismatches++;
        end else begin
          want = frames_due.pop_front();
          if (m_axis_tdata[1:0] !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_axis_tdata[1:0]);
            mismatches++;
          end
          if (m_axis_tdata[13:2] !== want.code) begin
            $error("code: expected %h, got %h", want.code, m_axis_tdata[13:2]);
            mismatches++;
          end
          if (m_axis_tdata[29:14] !== want.sync_width) begin
            $error("sync_width_us: expected %0d, got %0d", want.sync_width,
                   m_axis_tdata[29:14]);
            mismatches++;
          end
          if (m_axis_tdata[30] !== want.groups_ok) begin
            $error("groups_ok: expected %0d, got %0d", want.groups_ok, m_axis_tdata[30]);
            mismatches++;
          end
        end
      end
      if (cfg_we_i) begin
        case (cfg_idx_i)
          rfd_pkg::CFG_UNIT: unit_us = cfg_data_i[rfd_pkg::UNIT_W-1:0];
          rfd_pkg::CFG_TOL:  tol_us  = cfg_data_i[rfd_pkg::TOL_W-1:0];
          rfd_pkg::CFG_GAP:  gap_us  = cfg_data_i[rfd_pkg::GAP_W-1:0];
          default:  ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) take_interval(s_axis_tdata);
      mismatches_o     <= mismatches;
      frames_pending_o <= frames_due.size();
    end
  end

endmodule

// ===== tb/rf_remote_pulse_frame_decoder_test.sv =====
`timescale 1ns / 100ps
// Top of the pulse frame decoder testbench: clock, reset, settings, interval stimulus, verdict.
module rf_remote_pulse_frame_decoder_test;

  logic                       clk_i         = 1'b0;
  logic                       rst_ni        = 1'b0;
  logic                       cfg_we_i      = 1'b0;
  logic [rfd_pkg::CIDX_W-1:0] cfg_idx_i     = '0;
  logic [rfd_pkg::CFG_W-1:0]  cfg_data_i    = '0;
  logic                       s_axis_tvalid = 1'b0;
  logic                       s_axis_tready;
  logic [15:0]                s_axis_tdata  = '0;
  logic                       m_axis_tvalid;
  logic                       m_axis_tready = 1'b0;
  logic [31:0]                m_axis_tdata;
  int                         mismatches;
  int                         frames_pending;

  bit          calm           = 1'b0;  // no idling on either side
  int unsigned ready_hold     = 0;
  int unsigned gap_pct        = 0;
  int unsigned intervals_sent = 0;
  int          unit_cur       = int'(rfd_pkg::UNIT_RST);
  int          tol_cur        = int'(rfd_pkg::TOL_RST);
  int          gap_cur        = int'(rfd_pkg::GAP_RST);

  // Opening intervals at reset settings: gap on an empty ring, sync at the threshold,
  // sync at both short edges and just outside them, zero sync, one lone bit group
  logic [15:0] opening_widths [19] = '{16'hFFFF, 16'd5000, 16'd5001, 16'd225, 16'hFFFF,
                                       16'd375, 16'd5001, 16'd224, 16'd6000, 16'd376,
                                       16'd7000, 16'd0, 16'd32768, 16'd300, 16'd900,
                                       16'd300, 16'd100, 16'd300, 16'd5001};

  always #5 clk_i = ~clk_i;

  rf_remote_pulse_frame_decoder i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  rf_pulse_frame_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .mismatches_o     (mismatches),
    .frames_pending_o (frames_pending)
  );

  // Hard stop for a hung run
  initial begin
    #8_000_000;
    $display("Regression FAIL");
    $finish;
  end

  // Result side: always ready when calm, else stall at random between ready stretches
  always @(posedge clk_i) begin
    if (calm) begin
      m_axis_tready <= 1'b1;
    end else if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if ($urandom_range(0, 2) == 0) begin
      m_axis_tready <= 1'b0;
      ready_hold    <= $urandom_range(0, 12);
    end else begin
      m_axis_tready <= 1'b1;
      ready_hold    <= $urandom_range(0, 30);
    end
  end

  // Offer one interval, maybe after an idle burst, and hold it until accepted
  task automatic send_interval(input logic [15:0] width);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= width;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    intervals_sent++;
  endtask

  // Drop valid, wait out every pending result and the decode latency
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (frames_pending != 0) @(posedge clk_i);
    repeat (64) @(posedge clk_i);
  endtask

  task automatic load_settings(input logic [rfd_pkg::UNIT_W-1:0] unit,
                               input logic [rfd_pkg::TOL_W-1:0] tol,
                               input logic [rfd_pkg::GAP_W-1:0] gap);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= rfd_pkg::CFG_UNIT;
    cfg_data_i <= rfd_pkg::CFG_W'(unit);
    @(posedge clk_i);
    cfg_idx_i  <= rfd_pkg::CFG_TOL;
    cfg_data_i <= rfd_pkg::CFG_W'(tol);
    @(posedge clk_i);
    cfg_idx_i  <= rfd_pkg::CFG_GAP;
    cfg_data_i <= rfd_pkg::CFG_W'(gap);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    unit_cur = int'(unit);
    tol_cur  = int'(tol);
    gap_cur  = int'(gap);
  endtask

  // Random width in [lo, hi], clipped so that it is stored, never a gap
  function automatic logic [15:0] pick_width(input int lo, input int hi);
    int a, b;
    a = (lo < 0) ? 0 : lo;
    b = (hi > gap_cur) ? gap_cur : hi;
    if (a > b) a = b;
    return 16'($urandom_range(b, a));
  endfunction

  function automatic logic [15:0] short_width();
    return pick_width(unit_cur - tol_cur, unit_cur + tol_cur);
  endfunction

  function automatic logic [15:0] long_width();
    return pick_width(3 * (unit_cur - tol_cur), 3 * (unit_cur + tol_cur));
  endfunction

  function automatic logic [15:0] gap_width();
    case ($urandom_range(0, 7))
      0:       return 16'(gap_cur + 1);
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(65535, gap_cur + 1));
    endcase
  endfunction

  // Twelve groups, first bit first, then the sync pulse and the gap;
  // bad_slot corrupts one group interval (0..47) or the sync pulse (48)
  task automatic send_frame(input logic [rfd_pkg::CODE_BITS-1:0] code, input int bad_slot);
    logic [15:0] width;
    int          slot;
    slot = 0;
    for (int b = rfd_pkg::CODE_BITS - 1; b >= 0; b--) begin
      for (int k = 0; k < 4; k++) begin
        case (k)
          0:       width = short_width();
          1:       width = long_width();
          2:       width = code[b] ? short_width() : long_width();
          default: width = pick_width(0, gap_cur);
        endcase
        if (slot == bad_slot) width = pick_width(0, gap_cur);
        send_interval(width);
        slot++;
      end
    end
    send_interval((bad_slot == 48) ? pick_width(0, gap_cur) : short_width());
    send_interval(gap_width());
  endtask

  // One frame, broken frame or short noise run, each ending in exactly one gap
  task automatic run_episode();
    int                            kind;
    int                            count;
    logic [rfd_pkg::CODE_BITS-1:0] code;
    gap_pct = ($urandom_range(0, 2) == 0) ? 0 : 25;
    kind    = int'($urandom_range(0, 99));
    case ($urandom_range(0, 7))
      0:       code = '0;
      1:       code = '1;
      2:       code = 12'd1 << $urandom_range(0, rfd_pkg::CODE_BITS - 1);
      default: code = rfd_pkg::CODE_BITS'($urandom_range(4095, 0));
    endcase
    if (kind < 55) begin
      send_frame(code, -1);
    end else if (kind < 72) begin
      send_frame(code, int'($urandom_range(0, 48)));
    end else begin
      count = int'($urandom_range(0, 5));
      repeat (count) send_interval(pick_width(0, gap_cur));
      if ($urandom_range(0, 1) == 0) send_interval(short_width());
      send_interval(gap_width());
    end
  endtask

  initial begin
    int unsigned phase_start;
    int unsigned phase_frames;
    int          u, t, g;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (opening_widths[i]) send_interval(opening_widths[i]);
    settle();

    // Settings: reset values, both extremes, tolerance above unit, then random
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: load_settings(rfd_pkg::UNIT_RST, rfd_pkg::TOL_RST, rfd_pkg::GAP_RST);
        1: load_settings(12'd1, 11'd0, 15'd1);
        2: load_settings(12'd4095, 11'd2047, 15'd32767);
        3: load_settings(12'd500, 11'd700, 15'd8000);
        default: begin
          u = int'($urandom_range(100, 1500));
          t = int'($urandom_range(0, u / 4));
          g = int'($urandom_range(32767, 3 * (u + t) + 1));
          load_settings(rfd_pkg::UNIT_W'(u), rfd_pkg::TOL_W'(t), rfd_pkg::GAP_W'(g));
        end
      endcase
      calm         = (ph == 5);
      phase_start  = intervals_sent;
      phase_frames = 0;
      while (intervals_sent - phase_start < 150 || phase_frames < 6) begin
        run_episode();
        phase_frames++;
      end
      settle();
    end

    if (mismatches == 0 && frames_pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
